FILE: hw/rtl/vdtt_pkg.sv
// Package: shared types, constants and window functions for the voxel deletion test.
package vdtt_pkg;

    localparam int unsigned WinBits   = 27;
    localparam int unsigned Centre    = 13;
    localparam int unsigned NumFaces  = 6;
    localparam int unsigned LabW      = 5;
    localparam int unsigned SubcubeFull = 7;

    typedef logic [WinBits-1:0] t_win;
    typedef logic [LabW-1:0]    t_lab;

    // face neighbours in compare order
    localparam int unsigned FaceIdx [NumFaces] = '{4, 22, 10, 16, 12, 14};

    // controller -> datapath commands
    typedef struct packed {
        logic load;
        logic seed;
        logic step;
        logic next_pass;
        logic finish;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic has_seed;
        logic stable;
        logic pass;
    } t_sts;

    // voxels whose coordinate on one axis (1: y, 2: z) is not at a given value
    function automatic t_win axis_mask(input int unsigned axis, input int unsigned avoid);
        t_win m;
        int unsigned c;
        m = '0;
        for (int unsigned i = 0; i < WinBits; i++) begin
            c = (axis == 1) ? (i / 3) % 3 : i % 3;
            if (c != avoid) m[i] = 1'b1;
        end
        return m;
    endfunction

    localparam t_win MaskNy2 = axis_mask(1, 2);
    localparam t_win MaskNy0 = axis_mask(1, 0);
    localparam t_win MaskNz2 = axis_mask(2, 2);
    localparam t_win MaskNz0 = axis_mask(2, 0);

    // one 6-connected growth step
    function automatic t_win grow(input t_win r);
        return r | (r << 9) | (r >> 9) | ((r & MaskNy2) << 3) | ((r & MaskNy0) >> 3)
             | ((r & MaskNz2) << 1) | ((r & MaskNz0) >> 1);
    endfunction

    // two set faces with a clear shared edge voxel
    function automatic logic edge_veto(input t_win w);
        return (w[22] & w[16] & ~w[25]) | (w[4]  & w[10] & ~w[1])
             | (w[22] & w[10] & ~w[19]) | (w[4]  & w[16] & ~w[7])
             | (w[22] & w[14] & ~w[23]) | (w[4]  & w[14] & ~w[5])
             | (w[4]  & w[12] & ~w[3])  | (w[22] & w[12] & ~w[21])
             | (w[16] & w[14] & ~w[17]) | (w[10] & w[14] & ~w[11])
             | (w[10] & w[12] & ~w[9])  | (w[16] & w[12] & ~w[15]);
    endfunction

    // clear corner with the other seven voxels of its subcube set
    function automatic logic corner_veto(input t_win w);
        logic v;
        int unsigned cx, cy, cz, cnt;
        v = 1'b0;
        for (int unsigned c = 0; c < 8; c++) begin
            cx = c[2] ? 2 : 0;
            cy = c[1] ? 2 : 0;
            cz = c[0] ? 2 : 0;
            cnt = 0;
            for (int unsigned k = 0; k < 8; k++) begin
                cnt += w[(k[2] ? 1 : cx) * 9 + (k[1] ? 1 : cy) * 3 + (k[0] ? 1 : cz)];
            end
            if (!w[cx * 9 + cy * 3 + cz] && cnt == SubcubeFull) v = 1'b1;
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/vdtt_if.sv
// Interfaces: input window channel and result channel.
interface vdtt_in_if;
    logic                     valid;
    logic                     ready;
    logic [vdtt_pkg::WinBits-1:0] neighbourhood;
    modport source (output valid, output neighbourhood, input ready);
    modport sink   (input valid, input neighbourhood, output ready);
endinterface

interface vdtt_out_if;
    logic valid;
    logic ready;
    logic deletable;
    modport source (output valid, output deletable, input ready);
    modport sink   (input valid, input deletable, output ready);
endinterface

FILE: hw/rtl/vdtt_dp.sv
// Datapath: window, flood register, label bookkeeping and veto logic.
module vdtt_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  vdtt_pkg::t_cmd             i_cmd,
    input  vdtt_pkg::t_win             i_win,
    output vdtt_pkg::t_sts             o_sts,
    output logic                       o_deletable
);
    vdtt_pkg::t_win r_win, r_reach, r_same, r_labeled;
    vdtt_pkg::t_lab r_n;
    vdtt_pkg::t_lab r_lab [2][vdtt_pkg::NumFaces];
    logic           r_pass, r_del;

    vdtt_pkg::t_win w_cur, w_free, w_seed, w_grow;
    logic           w_mis;

    // window of the current pass: second pass has the centre cleared
    always_comb begin
        w_cur = r_win;
        if (r_pass) w_cur[vdtt_pkg::Centre] = 1'b0;
        w_free = ~r_labeled;
        w_free[vdtt_pkg::Centre] = 1'b0;
        w_seed = w_free & (~w_free + vdtt_pkg::t_win'(1));
        w_grow = vdtt_pkg::grow(r_reach) & r_same;
    end

    // label mismatch on any face
    always_comb begin
        w_mis = 1'b0;
        for (int k = 0; k < vdtt_pkg::NumFaces; k++) begin
            if (r_lab[0][k] != r_lab[1][k]) w_mis = 1'b1;
        end
    end

    assign o_sts.has_seed = |w_free;
    assign o_sts.stable   = (w_grow == r_reach);
    assign o_sts.pass     = r_pass;
    assign o_deletable    = r_del;

    // control-like bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass    <= 1'b0;
            r_labeled <= '0;
            r_n       <= '0;
        end else if (i_cmd.load) begin
            r_pass    <= 1'b0;
            r_labeled <= '0;
            r_n       <= '0;
        end else if (i_cmd.next_pass) begin
            r_pass    <= 1'b1;
            r_labeled <= '0;
            r_n       <= '0;
        end else if (i_cmd.step && o_sts.stable) begin
            r_labeled <= r_labeled | r_reach;
            r_n       <= r_n + vdtt_pkg::t_lab'(1);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_win <= i_win;
        if (i_cmd.seed) begin
            r_reach <= w_seed;
            r_same  <= ((w_cur & w_seed) != '0) ? w_cur : ~w_cur;
        end else if (i_cmd.step) begin
            r_reach <= w_grow;
        end
        if (i_cmd.step && o_sts.stable) begin
            for (int k = 0; k < vdtt_pkg::NumFaces; k++) begin
                if (r_reach[vdtt_pkg::FaceIdx[k]]) r_lab[r_pass][k] <= r_n;
            end
        end
        if (i_cmd.finish) begin
            r_del <= ~(vdtt_pkg::edge_veto(r_win) | vdtt_pkg::corner_veto(r_win) | w_mis);
        end
    end
endmodule

FILE: hw/rtl/vdtt_ctrl.sv
// Controller: sequences seed search, flooding and the two labelling passes.
module vdtt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  vdtt_pkg::t_sts i_sts,
    output vdtt_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SEED  = 4'b0010,
        S_FLOOD = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEED;
                end
            end
            S_SEED: begin
                priority if (i_sts.has_seed) begin
                    o_cmd.seed = 1'b1;
                    n_state    = S_FLOOD;
                end else if (!i_sts.pass) begin
                    o_cmd.next_pass = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_FLOOD: begin
                o_cmd.step = 1'b1;
                if (i_sts.stable) n_state = S_SEED;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // a new window always starts with a seed search
    a_load_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state == S_SEED)
        else $error("load did not go to seed search");
    // flooding is only entered from a seed
    a_flood_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLOOD && !$past(r_state == S_FLOOD)) |-> $past(r_state == S_SEED))
        else $error("flood entered without seed");
    // never take a window while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready with result pending");
endmodule

FILE: hw/rtl/voxel_deletion_topology_test_core.sv
// Top level: voxel deletion topology test core.
// Takes one 27-bit 3x3x3 window a beat and returns one deletable flag per window.
// A window is accepted only when the core is idle, so windows are handled one at a time.
// Per window the controller accepts it, then in each of the two labelling passes seeds
// every component in turn and floods it until a growth step leaves it unchanged, with one
// end-of-pass check per pass, and then presents the result beat. Fewest seeds come from a
// uniform window and most from a 6-connected checkerboard, where every voxel is a
// component of its own. The result beat waits until it is taken, and the next window
// can be accepted in the cycle after.
module voxel_deletion_topology_test_core (
    input  logic i_clk,
    input  logic i_rst_n,
    vdtt_in_if.sink    i_in,
    vdtt_out_if.source o_out
);
    vdtt_pkg::t_cmd w_cmd;
    vdtt_pkg::t_sts w_sts;

    vdtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    vdtt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_win       (i_in.neighbourhood),
        .o_sts       (w_sts),
        .o_deletable (o_out.deletable)
    );
endmodule

FILE: verif/voxel_deletion_topology_test_core_tb.sv
// Self-checking testbench for the voxel deletion topology test core.
module voxel_deletion_topology_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom = 750;
    localparam int NumDirected = 16;
    localparam logic [26:0] WinAll = 27'h7FFFFFF;

    // directed row: window, whether the expected flag is typed in, and its value
    typedef struct packed {
        vdtt_pkg::t_win win;
        logic fixed;
        logic flag;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    vdtt_in_if  win_ch ();
    vdtt_out_if res_ch ();

    voxel_deletion_topology_test_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (win_ch.sink),
        .o_out  (res_ch.source)
    );

    logic flag_q [$];
    int   n_fail;
    int   n_got;
    int   send_idle_pct;
    int   recv_stall_pct;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // voxels 6-connected to a seed within a same-valued set
    function automatic vdtt_pkg::t_win flood_region(vdtt_pkg::t_win seed, vdtt_pkg::t_win same);
        vdtt_pkg::t_win r;
        vdtt_pkg::t_win g;
        r = seed;
        for (int it = 0; it < 27; it++) begin
            g = r | (r << 9) | (r >> 9);
            for (int i = 0; i < 27; i++) begin
                if (r[i]) begin
                    if ((i / 3) % 3 != 2) g[i + 3] = 1'b1;
                    if ((i / 3) % 3 != 0) g[i - 3] = 1'b1;
                    if (i % 3 != 2) g[i + 1] = 1'b1;
                    if (i % 3 != 0) g[i - 1] = 1'b1;
                end
            end
            g = g & same;
            if (g == r) break;
            r = g;
        end
        return r;
    endfunction

    // component numbers in scan order; the centre never seeds
    function automatic void number_parts(vdtt_pkg::t_win occ, output int lab [27]);
        int n;
        vdtt_pkg::t_win same;
        vdtt_pkg::t_win reach;
        n = 0;
        for (int i = 0; i < 27; i++) lab[i] = -1;
        for (int i = 0; i < 27; i++) begin
            if (i == 13 || lab[i] >= 0) continue;
            same = occ[i] ? occ : ~occ;
            reach = flood_region(vdtt_pkg::t_win'(1) << i, same);
            for (int j = 0; j < 27; j++) if (reach[j]) lab[j] = n;
            n++;
        end
    endfunction

    function automatic logic centre_deletable(vdtt_pkg::t_win w);
        int pre [27];
        int post [27];
        int faces [6];
        int cx, cy, cz, cnt;
        logic veto;
        faces = '{4, 22, 10, 16, 12, 14};
        veto = 1'b0;
        // edge rule: two faces at right angles set, their shared edge voxel clear
        for (int a = 0; a < 6; a++) begin
            for (int b = 0; b < 6; b++) begin
                if (faces[a] - 13 == -(faces[b] - 13) || a == b) continue;
                if (w[faces[a]] && w[faces[b]] && !w[faces[a] + faces[b] - 13]) veto = 1'b1;
            end
        end
        // corner rule: clear corner, rest of its subcube set
        for (int c = 0; c < 8; c++) begin
            cx = c[2] ? 2 : 0;
            cy = c[1] ? 2 : 0;
            cz = c[0] ? 2 : 0;
            cnt = 0;
            for (int k = 0; k < 8; k++)
                cnt += w[(k[2] ? 1 : cx) * 9 + (k[1] ? 1 : cy) * 3 + (k[0] ? 1 : cz)];
            if (!w[cx * 9 + cy * 3 + cz] && cnt == 7) veto = 1'b1;
        end
        // label rule: face numbers must survive removing the centre
        number_parts(w, pre);
        number_parts(w & ~(vdtt_pkg::t_win'(1) << 13), post);
        for (int k = 0; k < 6; k++) if (pre[faces[k]] != post[faces[k]]) veto = 1'b1;
        return !veto;
    endfunction

    // one window beat, held until accepted; ready only moves at the rising edge,
    // so its value at the falling edge tells whether the next rising edge accepts
    task automatic send_window(vdtt_pkg::t_win w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            win_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        win_ch.valid <= 1'b1;
        win_ch.neighbourhood <= w;
        while (!win_ch.ready) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // random window: plain, dense or sparse; centre mostly set, sometimes clear or left random
    function automatic vdtt_pkg::t_win rand_window();
        vdtt_pkg::t_win w;
        int mode;
        mode = $urandom_range(3);
        w = vdtt_pkg::t_win'($urandom);
        if (mode == 1) w = w | vdtt_pkg::t_win'($urandom) | vdtt_pkg::t_win'($urandom);
        if (mode == 2) w = w & vdtt_pkg::t_win'($urandom) & vdtt_pkg::t_win'($urandom);
        if ($urandom_range(9) == 0) w[13] = 1'b0;
        else if (mode != 3) w[13] = 1'b1;
        return w;
    endfunction

    // result checking at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_got++;
            if (flag_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result beat: deletable=%0b", res_ch.deletable);
            end else begin
                if (res_ch.deletable !== flag_q[0]) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("deletable mismatch: expected %0b actual %0b",
                                 flag_q[0], res_ch.deletable);
                end
                void'(flag_q.pop_front());
            end
        end
    end

    // receiver ready, stalled at random
    always @(negedge i_clk) begin
        res_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_row rows [NumDirected];
        vdtt_pkg::t_win w;
        int drain;
        rows = '{
            '{27'h0000000, 1'b1, 1'b1},   // empty window
            '{WinAll,      1'b1, 1'b1},   // full window: shell stays one component
            '{27'h0002000, 1'b1, 1'b1},   // isolated centre: clear shell stays one component
            '{27'h0402010, 1'b0, 1'b0},   // two opposite faces and the centre
            '{27'h2402010, 1'b0, 1'b0},   // two opposite faces, centre and an edge voxel
            '{27'h7FFFFFE, 1'b0, 1'b0},   // one clear corner
            '{27'h7FFDFFF, 1'b0, 1'b0},   // full but centre clear
            '{27'h0006000, 1'b0, 1'b0},   // centre and one face
            '{27'h0007000, 1'b0, 1'b0},   // line through centre
            '{27'h1FF0000, 1'b0, 1'b0},   // nine voxels from bit 16 up, centre clear
            '{27'h1FF2000, 1'b0, 1'b0},   // the same nine voxels plus centre
            '{27'h0000001, 1'b0, 1'b0},   // lone corner
            '{27'h4000000, 1'b0, 1'b0},   // top bit only
            '{27'h5555555, 1'b0, 1'b0},
            '{27'h2AAAAAA, 1'b0, 1'b0},
            '{27'h0492492, 1'b0, 1'b0}
        };
        n_fail = 0;
        n_got = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        win_ch.valid = 1'b0;
        win_ch.neighbourhood = '0;
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[r]) begin
            flag_q.push_back(rows[r].fixed ? rows[r].flag : centre_deletable(rows[r].win));
            send_window(rows[r].win);
        end

        // random windows across the idling phases
        for (int k = 0; k < NumRandom; k++) begin
            case (k * 5 / NumRandom)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                3: begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            w = rand_window();
            flag_q.push_back(centre_deletable(w));
            send_window(w);
        end
        win_ch.valid <= 1'b0;

        recv_stall_pct = 0;
        drain = 0;
        while (flag_q.size() != 0 && drain < 200000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (100) @(negedge i_clk);
        if (n_fail == 0 && flag_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
